[src/csa_pkg.sv]
// Shared types and fixed widths for the cone surface anchor pipeline.
`default_nettype none
package csa_pkg;
    localparam int SQ_W  = 64;   // width of x^2 + y^2
    localparam int R_W   = 32;   // width of the integer square root
    localparam int D_W   = 36;   // width of the signed divisor 4r + 2z
    localparam int DIV_W = 35;   // width of the divisor magnitude
    localparam int SQ_STEPS = SQ_W / 2;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zero;
    } t_vec;

    typedef struct packed {
        logic [DIV_W-1:0] ub;
        logic [2:0]       neg;
        logic             zero;
    } t_div_side;
endpackage
`default_nettype wire

[src/csa_in_if.sv]
// Input channel carrying one direction vector per transfer.
`default_nettype none
interface csa_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface
`default_nettype wire

[src/csa_out_if.sv]
// Output channel carrying one surface anchor point per transfer.
`default_nettype none
interface csa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] anchor_x;
    logic signed [31:0] anchor_y;
    logic signed [31:0] anchor_z;
    logic               degenerate;
    modport source (output valid, anchor_x, anchor_y, anchor_z, degenerate, input ready);
    modport sink (input valid, anchor_x, anchor_y, anchor_z, degenerate, output ready);
endinterface
`default_nettype wire

[src/cone_surface_anchor.sv]
// Top level: square root chain, divisor selection and division chain.
// Throughput: one vector per cycle; the whole pipeline advances together and
// holds only while the output register is full and not taken.
// Reset: synchronous active-low reset clears every stage valid bit; data is not reset.
`default_nettype none
module cone_surface_anchor
    import csa_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    csa_in_if.sink    i_dir,
    csa_out_if.source o_anchor
);
    localparam int NUM_W = 33 + FRAC_BITS;

    logic en;
    logic r_out_valid;
    assign en          = !r_out_valid || o_anchor.ready;
    assign i_dir.ready = en;

    // Input and squaring stages.
    logic            r_a_valid, r_b_valid, r_c_valid;
    t_vec            r_a_vec, r_b_vec, r_c_vec;
    logic [63:0]     r_b_sx, r_b_sy;
    logic [SQ_W-1:0] r_c_sq;
    logic [31:0]     ax, ay;

    assign ax = r_a_vec.x[31] ? 32'(-r_a_vec.x) : r_a_vec.x;
    assign ay = r_a_vec.y[31] ? 32'(-r_a_vec.y) : r_a_vec.y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_dir.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_vec.x    <= i_dir.dir_x;
            r_a_vec.y    <= i_dir.dir_y;
            r_a_vec.z    <= i_dir.dir_z;
            r_a_vec.zero <= (i_dir.dir_x == 32'sd0) && (i_dir.dir_y == 32'sd0)
                            && (i_dir.dir_z == 32'sd0);
            r_b_sx       <= {32'd0, ax} * {32'd0, ax};
            r_b_sy       <= {32'd0, ay} * {32'd0, ay};
            r_b_vec      <= r_a_vec;
            r_c_sq       <= r_b_sx + r_b_sy;
            r_c_vec      <= r_b_vec;
        end
    end

    // Square root chain.
    logic [SQ_STEPS:0]           s_valid;
    logic [SQ_STEPS:0][SQ_W-1:0] s_v;
    logic [SQ_STEPS:0][SQ_W-1:0] s_res;
    t_vec [SQ_STEPS:0]           s_vec;

    assign s_valid[0] = r_c_valid;
    assign s_v[0]     = r_c_sq;
    assign s_res[0]   = '0;
    assign s_vec[0]   = r_c_vec;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        csa_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[k]),
            .i_v     (s_v[k]),
            .i_res   (s_res[k]),
            .i_vec   (s_vec[k]),
            .o_valid (s_valid[k+1]),
            .o_v     (s_v[k+1]),
            .o_res   (s_res[k+1]),
            .o_vec   (s_vec[k+1])
        );
    end

    // Divisor selection: base plane when 2|z| exceeds |4r + 2z|.
    t_vec                  sv;
    logic [R_W-1:0]        root;
    logic signed [D_W-1:0] d;
    logic [DIV_W-1:0]      dmag;
    logic [DIV_W-1:0]      zmag2;
    logic                  base;
    logic                  bneg;

    assign sv    = s_vec[SQ_STEPS];
    assign root  = s_res[SQ_STEPS][R_W-1:0];
    assign d     = $signed({2'b00, root, 2'b00}) + $signed({{3{sv.z[31]}}, sv.z, 1'b0});
    assign dmag  = d[D_W-1] ? DIV_W'(-d) : DIV_W'(d);
    assign zmag2 = sv.z[31] ? DIV_W'({1'b0, 32'(-sv.z), 1'b0}) : DIV_W'({1'b0, sv.z, 1'b0});
    assign base  = zmag2 > dmag;
    assign bneg  = !base && d[D_W-1];

    logic      r_d_valid;
    t_vec      r_d_vec;
    t_div_side r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= s_valid[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_vec       <= sv;
            r_d_side.ub   <= base ? zmag2 : dmag;
            r_d_side.neg  <= {sv.z[31] ^ bneg, sv.y[31] ^ bneg, sv.x[31] ^ bneg};
            r_d_side.zero <= sv.zero;
        end
    end

    // Rounded numerators |a| * 2^FRAC_BITS + ub/2.
    logic [2:0][31:0] amag;
    assign amag[0] = r_d_vec.x[31] ? 32'(-r_d_vec.x) : r_d_vec.x;
    assign amag[1] = r_d_vec.y[31] ? 32'(-r_d_vec.y) : r_d_vec.y;
    assign amag[2] = r_d_vec.z[31] ? 32'(-r_d_vec.z) : r_d_vec.z;

    localparam int DV_N = NUM_W;
    logic [DV_N:0]                v_valid;
    logic [DV_N:0][2:0][NUM_W-1:0] v_num;
    logic [DV_N:0][2:0][NUM_W-1:0] v_quo;
    logic [DV_N:0][2:0][DIV_W-1:0] v_rem;
    t_div_side [DV_N:0]            v_side;

    logic                   r_e_valid;
    logic [2:0][NUM_W-1:0]  r_e_num;
    t_div_side              r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e_num[i] <= (NUM_W'(amag[i]) << FRAC_BITS) + NUM_W'(r_d_side.ub >> 1);
            end
            r_e_side <= r_d_side;
        end
    end

    assign v_valid[0] = r_e_valid;
    assign v_num[0]   = r_e_num;
    assign v_quo[0]   = '0;
    assign v_rem[0]   = '0;
    assign v_side[0]  = r_e_side;

    for (genvar k = 0; k < DV_N; k++) begin : g_div
        csa_div_cell #(.NUM_W(NUM_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_valid[k]),
            .i_num   (v_num[k]),
            .i_quo   (v_quo[k]),
            .i_rem   (v_rem[k]),
            .i_side  (v_side[k]),
            .o_valid (v_valid[k+1]),
            .o_num   (v_num[k+1]),
            .o_quo   (v_quo[k+1]),
            .o_rem   (v_rem[k+1]),
            .o_side  (v_side[k+1])
        );
    end

    // Saturation, sign and output register.
    t_div_side        fs;
    logic [2:0][31:0] res;
    logic [NUM_W-1:0] q;
    logic [31:0]      qs;

    assign fs = v_side[DV_N];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q = v_quo[DV_N][i];
            if (fs.ub == '0) begin
                qs     = 32'd0;
                res[i] = 32'd0;
            end else if (fs.neg[i]) begin
                qs     = (q > NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : q[31:0];
                res[i] = 32'(-qs);
            end else begin
                qs     = (q > NUM_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
                res[i] = qs;
            end
        end
    end

    logic [2:0][31:0] r_res;
    logic             r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v_valid[DV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res   <= res;
            r_degen <= fs.zero;
        end
    end

    assign o_anchor.valid      = r_out_valid;
    assign o_anchor.anchor_x   = r_res[0];
    assign o_anchor.anchor_y   = r_res[1];
    assign o_anchor.anchor_z   = r_res[2];
    assign o_anchor.degenerate = r_degen;
endmodule
`default_nettype wire

[src/csa_sqrt_cell.sv]
// One bit step of the integer square root chain.
`default_nettype none
module csa_sqrt_cell
    import csa_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [SQ_W-1:0] i_v,
    input  wire logic [SQ_W-1:0] i_res,
    input  wire t_vec            i_vec,
    output logic                 o_valid,
    output logic [SQ_W-1:0]      o_v,
    output logic [SQ_W-1:0]      o_res,
    output t_vec                 o_vec
);
    localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (SQ_W - 2 - 2 * STEP);

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_v;
    logic [SQ_W-1:0] n_res;

    always_comb begin
        trial = i_res + BIT;
        if (i_v >= trial) begin
            n_v   = i_v - trial;
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v   <= n_v;
            o_res <= n_res;
            o_vec <= i_vec;
        end
    end
endmodule
`default_nettype wire

[src/csa_div_cell.sv]
// One restoring division step for the three vector components.
`default_nettype none
module csa_div_cell
    import csa_pkg::*;
#(
    parameter int NUM_W = 49
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [2:0][NUM_W-1:0] i_num,
    input  wire logic [2:0][NUM_W-1:0] i_quo,
    input  wire logic [2:0][DIV_W-1:0] i_rem,
    input  wire t_div_side            i_side,
    output logic                      o_valid,
    output logic [2:0][NUM_W-1:0]     o_num,
    output logic [2:0][NUM_W-1:0]     o_quo,
    output logic [2:0][DIV_W-1:0]     o_rem,
    output t_div_side                 o_side
);
    logic [2:0][DIV_W:0]     part;
    logic [2:0][NUM_W-1:0]   n_num;
    logic [2:0][NUM_W-1:0]   n_quo;
    logic [2:0][DIV_W-1:0]   n_rem;

    // While the divisor is nonzero, the partial remainder stays below it, so it fits DIV_W bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            part[i]  = {i_rem[i], i_num[i][NUM_W-1]};
            n_num[i] = i_num[i] << 1;
            if (part[i] >= {1'b0, i_side.ub}) begin
                n_rem[i] = DIV_W'(part[i] - {1'b0, i_side.ub});
                n_quo[i] = {i_quo[i][NUM_W-2:0], 1'b1};
            end else begin
                n_rem[i] = part[i][DIV_W-1:0];
                n_quo[i] = {i_quo[i][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num  <= n_num;
            o_quo  <= n_quo;
            o_rem  <= n_rem;
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

[tb/tb_cone_surface_anchor.sv]
// Self-checking testbench for the cone surface anchor pipeline.
`timescale 1ns / 100ps
`default_nettype none
module tb_cone_surface_anchor;
    import csa_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic               degen;
    } t_anchor;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    csa_in_if  dir_ch ();
    csa_out_if anchor_ch ();

    cone_surface_anchor #(.FRAC_BITS(FRAC)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (dir_ch.sink),
        .o_anchor (anchor_ch.source)
    );

    always #1 i_clk = ~i_clk;

    t_anchor anchors_due[$];
    int      n_mismatch = 0;
    int      idle_pct = 33;
    int      hold_cycles = 0;
    bit      sending_done = 1'b0;

    initial begin
        dir_ch.valid = 1'b0;
        dir_ch.dir_x = '0;
        dir_ch.dir_y = '0;
        dir_ch.dir_z = '0;
        anchor_ch.ready = 1'b0;
    end

    // Floor square root of a 64-bit sum, bit by bit from the top.
    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [31:0] res;
        logic [63:0] trial;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = {32'd0, res | (32'd1 << b)};
            if (trial * trial <= v)
                res = res | (32'd1 << b);
        end
        return res;
    endfunction

    // Rounded quotient a * 2^FRAC / b, ties away from zero, saturated.
    function automatic logic signed [31:0] scaled_quot(longint a, longint b);
        logic [127:0] ua, ub, q;
        bit neg;
        if (b == 0)
            return '0;
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        q = ((ua << FRAC) + ub / 2) / ub;
        neg = (a < 0) != (b < 0);
        if (neg) begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return -signed'(32'(q));
        end
        if (q > 128'h7FFF_FFFF)
            q = 128'h7FFF_FFFF;
        return 32'(q);
    endfunction

    function automatic t_anchor cone_exit(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z);
        t_anchor res;
        longint  xl, yl, zl, rl, dl, dv, az2, ad;
        logic [63:0] mx, my;
        xl = x;
        yl = y;
        zl = z;
        res = '0;
        if (x == 0 && y == 0 && z == 0) begin
            res.degen = 1'b1;
            return res;
        end
        mx = (xl < 0) ? 64'(-xl) : 64'(xl);
        my = (yl < 0) ? 64'(-yl) : 64'(yl);
        rl = longint'(floor_root(mx * mx + my * my));
        dl = 4 * rl + 2 * zl;
        az2 = 2 * ((zl < 0) ? -zl : zl);
        ad = (dl < 0) ? -dl : dl;
        dv = (az2 > ad) ? az2 : dl;
        res.ax = scaled_quot(xl, dv);
        res.ay = scaled_quot(yl, dv);
        res.az = scaled_quot(zl, dv);
        return res;
    endfunction

    // Valid drops only while idling, so back-to-back transfers keep it high.
    task automatic send_dir(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            dir_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        dir_ch.valid <= 1'b1;
        dir_ch.dir_x <= x;
        dir_ch.dir_y <= y;
        dir_ch.dir_z <= z;
        @(posedge i_clk);
        while (!dir_ch.ready)
            @(posedge i_clk);
        anchors_due.push_back(cone_exit(x, y, z));
    endtask

    // Receiver: random back-pressure, or a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            anchor_ch.ready <= 1'b0;
        end else begin
            anchor_ch.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_anchor got, want;
        if (i_rst_n && anchor_ch.valid && anchor_ch.ready) begin
            got = {anchor_ch.anchor_x, anchor_ch.anchor_y, anchor_ch.anchor_z,
                   anchor_ch.degenerate};
            if (anchors_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected transfer: %h", got);
            end else begin
                want = anchors_due.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h dg=%b got x=%h y=%h z=%h dg=%b",
                                 want.ax, want.ay, want.az, want.degen,
                                 got.ax, got.ay, got.az, got.degen);
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1: return signed'(32'($urandom_range(131072))) - 32'sd65536;
            2: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [31:0] v[6];
        v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd1, -32'sd1, 32'sd65536};
        send_dir(0, 0, 0);
        send_dir(0, 0, 32'sd65536);
        send_dir(0, 0, -32'sd65536);
        send_dir(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_dir(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        // 4r + 2z vanishes: r = 65536, z = -131072.
        send_dir(32'sd65536, 0, -32'sd131072);
        send_dir(0, 32'sd3, -32'sd6);
        for (int i = 0; i < 6; i++)
            send_dir(v[i], v[5 - i], v[(i + 2) % 6]);
        send_dir(32'sd65536, 0, 0);
        send_dir(1, 0, -32'sh7FFF_FFFF);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_dir(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic test_no_idle(int n);
        idle_pct = 0;
        test_random(n);
        idle_pct = 33;
    endtask

    task automatic test_fill_stall();
        hold_cycles <= 200;
        idle_pct = 0;
        test_random(120);
        idle_pct = 33;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(400);
        test_no_idle(200);
        test_fill_stall();
        test_random(180);
        dir_ch.valid <= 1'b0;
        while (anchors_due.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("** cone_surface_anchor: PASSED **");
        else
            $display("** cone_surface_anchor: FAILED **");
        $finish;
    end

    initial begin
        #200000;
        $display("** cone_surface_anchor: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
